// File: design/lgrs_pkg.sv
// shared types, constants and helpers for the led grid refresh sequencer
// no dependencies
package lgrs_pkg;

    localparam int GRID_W      = 4;
    localparam int BUF_DEPTH   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_FILL    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_REFRESH = 2'd3;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_FILL     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_REFRESH  = 2'd3;

    localparam logic [7:0] BYTE_DATA_CMD  = 8'h40;
    localparam logic [7:0] BYTE_ADDR_CMD  = 8'hC0;
    localparam logic [7:0] BYTE_CTRL_OFF  = 8'h80;
    localparam logic [7:0] BYTE_CTRL_ON   = 8'h88;
    localparam logic [3:0] LEVEL_RESET    = 4'd3;
    localparam logic [3:0] LEVEL_MAX      = 4'd8;

    typedef struct packed {
        logic [1:0]        kind;
        logic [GRID_W-1:0] grid;
        logic [7:0]        data;
    } t_op;

    function automatic logic [7:0] ctrl_byte(input logic [3:0] level);
        logic [3:0] lvl;
        lvl = (level > LEVEL_MAX) ? LEVEL_MAX : level;
        if (lvl == 4'd0) begin
            ctrl_byte = BYTE_CTRL_OFF;
        end else begin
            ctrl_byte = BYTE_CTRL_ON + {4'd0, lvl - 4'd1};
        end
    endfunction

endpackage

// File: design/lgrs_front.sv
// front end: takes command items, classifies them and pushes operations
// depends on lgrs_pkg
module lgrs_front
    import lgrs_pkg::*;
#(
    parameter int GRIDS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_cmd,
    input  logic [GRID_W-1:0] i_grid,
    input  logic [7:0]        i_segments,
    input  logic              i_full,
    output logic              o_push,
    output t_op               o_op
);

    logic w_accept;
    logic w_keep;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    // out-of-range writes are dropped here
    always_comb begin
        w_keep = 1'b1;
        o_op.grid = i_grid;
        o_op.data = i_segments;
        case (i_cmd)
            CMD_WRITE: begin
                o_op.kind = OP_WRITE;
                w_keep = ({1'b0, i_grid} < (GRID_W + 1)'(GRIDS));
            end
            CMD_FILL:    o_op.kind = OP_FILL;
            CMD_CLEAR:   o_op.kind = OP_CLEAR;
            CMD_REFRESH: o_op.kind = OP_REFRESH;
            default:     o_op.kind = OP_REFRESH;
        endcase
    end

    assign o_push = w_accept && w_keep;

endmodule

// File: design/lgrs_queue.sv
// short operation queue between front and back
// depends on lgrs_pkg
module lgrs_queue
    import lgrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_not_empty,
    output t_op  o_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_count;
    logic              w_push;
    logic              w_pop;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_op        = r_mem[r_rd];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_pop && o_not_empty;

    always_comb begin
        n_wr    = w_push ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// File: design/lgrs_back.sv
// back end: grid buffer, refresh sequencer and output register
// depends on lgrs_pkg
module lgrs_back
    import lgrs_pkg::*;
#(
    parameter int GRIDS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_not_empty,
    input  t_op        i_op,
    output logic       o_pop,
    input  logic [3:0] i_level,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_bus_byte,
    output logic       o_start_before,
    output logic       o_stop_after,
    output logic       o_last
);

    localparam int IDX_W = $clog2(GRIDS + 3);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic [7:0]        r_buf [BUF_DEPTH];
    logic [7:0]        n_buf [BUF_DEPTH];
    logic              r_state;
    logic              n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [7:0]        r_byte;
    logic [7:0]        n_byte;
    logic              r_start;
    logic              n_start;
    logic              r_stop;
    logic              n_stop;
    logic              r_last;
    logic              n_last;
    logic              w_load;
    logic [GRID_W-1:0] w_pos;

    assign w_load = !r_out_valid || !i_stall;
    assign o_pop  = (r_state == ST_IDLE) && i_not_empty;
    assign w_pos  = GRID_W'(r_idx - IDX_W'(2));

    always_comb begin
        n_buf       = r_buf;
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_start     = r_start;
        n_stop      = r_stop;
        n_last      = r_last;

        if (o_pop) begin
            case (i_op.kind)
                OP_WRITE: n_buf[i_op.grid] = i_op.data;
                OP_FILL: begin
                    for (int i = 0; i < BUF_DEPTH; i++) begin
                        if (i < GRIDS) begin
                            n_buf[i] = i_op.data;
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < BUF_DEPTH; i++) begin
                        n_buf[i] = 8'd0;
                    end
                end
                OP_REFRESH: begin
                    n_state = ST_SEND;
                    n_idx   = '0;
                end
                default: n_state = r_state;
            endcase
        end

        if (w_load) begin
            n_out_valid = 1'b0;
        end

        if ((r_state == ST_SEND) && w_load) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 1'b1;
            n_last      = 1'b0;
            if (r_idx == IDX_W'(0)) begin
                n_byte  = BYTE_DATA_CMD;
                n_start = 1'b1;
                n_stop  = 1'b1;
            end else if (r_idx == IDX_W'(1)) begin
                n_byte  = BYTE_ADDR_CMD;
                n_start = 1'b1;
                n_stop  = 1'b0;
            end else if (r_idx == IDX_W'(GRIDS + 2)) begin
                n_byte  = ctrl_byte(i_level);
                n_start = 1'b1;
                n_stop  = 1'b1;
                n_last  = 1'b1;
                n_state = ST_IDLE;
            end else begin
                n_byte  = r_buf[w_pos];
                n_start = 1'b0;
                n_stop  = (r_idx == IDX_W'(GRIDS + 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_start <= n_start;
        r_stop  <= n_stop;
        r_last  <= n_last;
        r_idx   <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BUF_DEPTH; i++) begin
                r_buf[i] <= 8'd0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_buf       <= n_buf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_bus_byte     = r_byte;
    assign o_start_before = r_start;
    assign o_stop_after   = r_stop;
    assign o_last         = r_last;

endmodule

// File: design/led_grid_refresh_sequencer.sv
// top level of the led grid refresh sequencer: front, queue, back, brightness register
// depends on lgrs_pkg, lgrs_front, lgrs_queue, lgrs_back
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  command  | in        | i_valid / o_stall       | i_cmd, i_grid, i_segments
//  bus byte | out       | o_valid / i_stall       | o_bus_byte, o_start_before,
//           |           |                         | o_stop_after, o_last
//  config   | in        | i_cfg_valid/o_cfg_ready | i_brightness_level
//
// the back end applies write, fill and clear items to the grid buffer as it pops them
// a refresh sends GRIDS + 3 bytes, one per cycle unless stalled; no items pop until it ends
// a four-entry queue lets items enter while a refresh drains; o_stall rises when it is full
// synchronous active-low reset clears the grid buffer and sets brightness level 3
module led_grid_refresh_sequencer
    import lgrs_pkg::*;
#(
    parameter int GRIDS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [3:0] i_grid,
    input  logic [7:0] i_segments,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_bus_byte,
    output logic       o_start_before,
    output logic       o_stop_after,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_brightness_level
);

    logic [3:0] r_level;
    t_op        w_push_op;
    t_op        w_head_op;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_not_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_level <= i_brightness_level;
        end
    end

    lgrs_front #(
        .GRIDS (GRIDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_grid     (i_grid),
        .i_segments (i_segments),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    lgrs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_op        (w_push_op),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_op        (w_head_op)
    );

    lgrs_back #(
        .GRIDS (GRIDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_not_empty    (w_not_empty),
        .i_op           (w_head_op),
        .o_pop          (w_pop),
        .i_level        (r_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_bus_byte     (o_bus_byte),
        .o_start_before (o_start_before),
        .o_stop_after   (o_stop_after),
        .o_last         (o_last)
    );

endmodule

// File: dv/led_grid_refresh_sequencer_test.sv
// self-checking testbench for led_grid_refresh_sequencer: random command items with gaps and
// stalls on both sides, predicted bus bytes checked in order against the monitored output
// depends on lgrs_pkg and led_grid_refresh_sequencer
module led_grid_refresh_sequencer_test;
    import lgrs_pkg::*;

    localparam int GRID_COUNT     = 16;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 21;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] grid;
        logic [7:0] segments;
    } t_cmd_item;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } t_bus_beat;

    logic       i_clk              = 1'b0;
    logic       i_rst_n            = 1'b0;
    logic       i_valid            = 1'b0;
    logic [1:0] i_cmd              = CMD_WRITE;
    logic [3:0] i_grid             = 4'd0;
    logic [7:0] i_segments         = 8'd0;
    logic       i_stall            = 1'b0;
    logic       i_cfg_valid        = 1'b0;
    logic [3:0] i_brightness_level = LEVEL_RESET;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_bus_byte;
    logic       o_start_before;
    logic       o_stop_after;
    logic       o_last;
    logic       o_cfg_ready;

    t_cmd_item  pending_items[$];
    t_bus_beat  expected_beats[$];
    t_cmd_item  item_on_bus;
    logic [7:0] grid_image [BUF_DEPTH];
    logic [3:0] level_image = LEVEL_RESET;
    bit         calm        = 1'b0;
    int         send_gap    = 0;
    int         recv_hold   = 0;
    int         idle_cycles = 0;
    int         mismatches  = 0;

    led_grid_refresh_sequencer #(
        .GRIDS(GRID_COUNT)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_cmd              (i_cmd),
        .i_grid             (i_grid),
        .i_segments         (i_segments),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_bus_byte         (o_bus_byte),
        .o_start_before     (o_start_before),
        .o_stop_after       (o_stop_after),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_brightness_level (i_brightness_level)
    );

    always #6 i_clk = ~i_clk;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [7:0] control_for_level(input logic [3:0] level);
        logic [3:0] steps;
        steps = (level > LEVEL_MAX) ? LEVEL_MAX : level;
        if (steps == 4'd0) begin
            return BYTE_CTRL_OFF;
        end
        return BYTE_CTRL_ON + 8'(steps - 4'd1);
    endfunction

    task automatic push_beat(input logic [7:0] b, input logic st, input logic sp,
                             input logic lst);
        t_bus_beat beat;
        beat.bus_byte     = b;
        beat.start_before = st;
        beat.stop_after   = sp;
        beat.last         = lst;
        expected_beats.push_back(beat);
    endtask

    task automatic update_display_image(input t_cmd_item it);
        case (it.cmd)
            CMD_WRITE: begin
                if (it.grid < GRID_COUNT) begin
                    grid_image[it.grid] = it.segments;
                end
            end
            CMD_FILL: begin
                for (int i = 0; i < GRID_COUNT && i < BUF_DEPTH; i++) begin
                    grid_image[i] = it.segments;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < BUF_DEPTH; i++) begin
                    grid_image[i] = 8'd0;
                end
            end
            default: begin
                push_beat(BYTE_DATA_CMD, 1'b1, 1'b1, 1'b0);
                push_beat(BYTE_ADDR_CMD, 1'b1, 1'b0, 1'b0);
                for (int i = 0; i < GRID_COUNT && i < BUF_DEPTH; i++) begin
                    push_beat(grid_image[i], 1'b0,
                              (i + 1 == GRID_COUNT) || (i + 1 == BUF_DEPTH), 1'b0);
                end
                push_beat(control_for_level(level_image), 1'b1, 1'b1, 1'b1);
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                update_display_image(item_on_bus);
                send_gap = draw_wait();
            end
            if (i_valid && o_stall) begin
                // held until taken
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                item_on_bus = pending_items.pop_front();
                i_cmd      <= item_on_bus.cmd;
                i_grid     <= item_on_bus.grid;
                i_segments <= item_on_bus.segments;
                i_valid    <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // bus byte monitor
    always @(posedge i_clk) begin
        t_bus_beat want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            recv_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: bus byte expected none actual %02h", $time, o_bus_byte);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("bus_byte", want.bus_byte, o_bus_byte);
                    compare_field("start_before", 8'(want.start_before),
                                  8'(o_start_before));
                    compare_field("stop_after", 8'(want.stop_after), 8'(o_stop_after));
                    compare_field("last", 8'(want.last), 8'(o_last));
                end
                recv_hold = draw_wait();
            end else if (recv_hold > 0) begin
                recv_hold--;
            end
            i_stall <= (recv_hold > 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [1:0] cmd, input logic [3:0] grid,
                              input logic [7:0] segments);
        t_cmd_item it;
        it.cmd      = cmd;
        it.grid     = grid;
        it.segments = segments;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(input int count);
        int pick;
        logic [1:0] cmd;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                cmd = CMD_WRITE;
            end else if (pick < 55) begin
                cmd = CMD_FILL;
            end else if (pick < 63) begin
                cmd = CMD_CLEAR;
            end else begin
                cmd = CMD_REFRESH;
            end
            queue_item(cmd, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
    endtask

    // block drained, then time for trailing writes still in the queue
    task automatic wait_quiet();
        while (pending_items.size() != 0 || i_valid || expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_level(input logic [3:0] level);
        @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_brightness_level <= level;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        level_image = level;
    endtask

    initial begin : stimulus
        logic [3:0] level;
        for (int i = 0; i < BUF_DEPTH; i++) begin
            grid_image[i] = 8'd0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset contents and reset brightness first
        queue_item(CMD_REFRESH, 4'd0, 8'h00);
        queue_item(CMD_WRITE, 4'd0, 8'hFF);
        queue_item(CMD_WRITE, 4'd15, 8'h01);
        queue_item(CMD_WRITE, 4'd8, 8'h80);
        queue_item(CMD_WRITE, 4'd7, 8'h7F);
        queue_item(CMD_REFRESH, 4'd15, 8'hFF);
        queue_item(CMD_FILL, 4'd9, 8'h55);
        queue_item(CMD_WRITE, 4'd3, 8'hAA);
        queue_item(CMD_REFRESH, 4'd0, 8'h00);
        queue_item(CMD_CLEAR, 4'd6, 8'hC3);
        queue_item(CMD_REFRESH, 4'd0, 8'h00);
        queue_item(CMD_FILL, 4'd0, 8'hFF);
        queue_item(CMD_WRITE, 4'd15, 8'h00);
        queue_item(CMD_REFRESH, 4'd10, 8'h5A);
        queue_item(CMD_FILL, 4'd15, 8'h00);
        queue_item(CMD_REFRESH, 4'd0, 8'h00);
        wait_quiet();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: level = 4'd0;
                1: level = LEVEL_MAX;
                2: level = 4'd15;
                3: level = 4'd1;
                4: level = 4'($urandom_range(2, 7));
                5: level = 4'($urandom_range(9, 14));
                default: level = 4'($urandom_range(0, 15));
            endcase
            set_level(level);
            calm = (p % 3 == 1);
            queue_random(PHASE_ITEMS);
            queue_item(CMD_REFRESH, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            wait_quiet();
        end

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
design/lgrs_pkg.sv
design/lgrs_front.sv
design/lgrs_queue.sv
design/lgrs_back.sv
design/led_grid_refresh_sequencer.sv
dv/led_grid_refresh_sequencer_test.sv
